// ===== rtl/bdlf_pkg.sv =====
// Package: shared constants, codes and types of the byte deque line finder.
package bdlf_pkg;

    localparam int DEPTH   = 256;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int TOTAL_W = 9;

    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_QUERY      = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN
    } cell_mode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/bdlf_cell.sv =====
// One byte cell of the deque chain: hold, or take a neighbor's byte.
module bdlf_cell (
    input  logic                clk,
    input  bdlf_pkg::cell_mode_t mode,
    input  logic [7:0]          from_left,
    input  logic [7:0]          from_right,
    output logic [7:0]          byte_q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        unique case (mode)
            bdlf_pkg::CELL_SHIFT_UP:   byte_next = from_left;
            bdlf_pkg::CELL_SHIFT_DOWN: byte_next = from_right;
            default:                   byte_next = byte_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

// ===== rtl/byte_deque_line_finder.sv =====
// Top level: byte deque held in a chain of cells, with a rotating newline scan.
// Order: an accepted item goes through EXEC, then SCAN, then DONE, where done is high.
// Items do not overlap: the scan rotates the whole cell chain once, one cell a cycle,
// and busy stays high until done has shown.
// Reset: state goes idle and the count goes to zero; the cell bytes are not reset.
// The receiver cannot stall: done shows for one cycle; results hold until the next op.
module byte_deque_line_finder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [2:0]                          op,
    input  logic [7:0]                          data_byte,
    output logic                                done,
    output logic [7:0]                          popped_byte,
    output logic [1:0]                          status,
    output logic [bdlf_pkg::TOTAL_W-1:0]        element_total,
    output logic signed [bdlf_pkg::TOTAL_W-1:0] newline_position
);

    // Between operations cell 0 holds the front byte; cell k the byte k places behind it.
    // Push front shifts the chain up and injects the byte at cell 0. Pop front
    // shifts it down. Back-end operations and the newline search ride on the
    // scan: the chain rotates down DEPTH times, so at scan step k cell 0 shows
    // logical index k, and after the last step every byte is back in place.

    bdlf_pkg::state_t     state_reg, state_next;
    logic [bdlf_pkg::CNT_W-1:0] count_reg, count_next;
    logic [bdlf_pkg::CNT_W-1:0] scan_reg, scan_next;

    logic [2:0]  op_reg, op_next;
    logic [7:0]  data_reg, data_next;
    logic [7:0]  popped_reg, popped_next;
    logic [1:0]  status_reg, status_next;
    logic        push_back_reg, push_back_next;
    logic        pop_back_reg, pop_back_next;
    logic        found_reg, found_next;
    logic [bdlf_pkg::TOTAL_W-1:0] pos_reg, pos_next;

    bdlf_pkg::cell_mode_t cell_mode;
    logic [7:0] cell_q [bdlf_pkg::DEPTH];
    logic [7:0] front_byte;
    logic [7:0] scan_byte;
    logic       is_full;
    logic       is_empty;
    logic       scan_last;

    // ---------------------------------------------------------------- cell chain
    genvar gi;
    generate
        for (gi = 0; gi < bdlf_pkg::DEPTH; gi++)
        begin : g_cell
            logic [7:0] left_in;
            logic [7:0] right_in;
            if (gi == 0)
            begin : g_first
                assign left_in = data_reg;
            end
            else
            begin : g_inner_left
                assign left_in = cell_q[gi-1];
            end
            if (gi == bdlf_pkg::DEPTH - 1)
            begin : g_last
                assign right_in = scan_byte;
            end
            else
            begin : g_inner_right
                assign right_in = cell_q[gi+1];
            end
            bdlf_cell u_cell (
                .clk        (clk),
                .mode       (cell_mode),
                .from_left  (left_in),
                .from_right (right_in),
                .byte_q     (cell_q[gi])
            );
        end
    endgenerate

    assign front_byte = cell_q[0];
    assign is_full    = (count_reg == bdlf_pkg::CNT_W'(bdlf_pkg::DEPTH));
    assign is_empty   = (count_reg == '0);
    assign scan_last  = (scan_reg == bdlf_pkg::CNT_W'(bdlf_pkg::DEPTH - 1));

    // A pending push back lands on the slot just past the old tail as it rotates
    // by; the byte fed back to the top of the chain is then the pushed one.
    always_comb
    begin
        if (state_reg == bdlf_pkg::ST_SCAN && push_back_reg
            && scan_reg == count_reg - bdlf_pkg::CNT_W'(1))
        begin
            scan_byte = data_reg;
        end
        else
        begin
            scan_byte = front_byte;
        end
    end

    // ---------------------------------------------------------------- control
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        op_next        = op_reg;
        data_next      = data_reg;
        popped_next    = popped_reg;
        status_next    = status_reg;
        push_back_next = push_back_reg;
        pop_back_next  = pop_back_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        cell_mode      = bdlf_pkg::CELL_HOLD;
        busy           = 1'b1;
        done           = 1'b0;

        unique case (state_reg)
            bdlf_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    op_next    = op;
                    data_next  = data_byte;
                    state_next = bdlf_pkg::ST_EXEC;
                end
            end

            bdlf_pkg::ST_EXEC:
            begin
                // Apply the operation; back-end work is deferred to the scan.
                popped_next    = 8'd0;
                status_next    = bdlf_pkg::STATUS_OK;
                push_back_next = 1'b0;
                pop_back_next  = 1'b0;
                found_next     = 1'b0;
                pos_next       = '1;
                scan_next      = '0;
                state_next     = bdlf_pkg::ST_SCAN;
                unique case (op_reg)
                    bdlf_pkg::OP_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = bdlf_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            cell_mode  = bdlf_pkg::CELL_SHIFT_UP;
                            count_next = count_reg + bdlf_pkg::CNT_W'(1);
                        end
                    end
                    bdlf_pkg::OP_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = bdlf_pkg::STATUS_FULL;
                        end
                        else
                        begin
                            push_back_next = 1'b1;
                            count_next     = count_reg + bdlf_pkg::CNT_W'(1);
                        end
                    end
                    bdlf_pkg::OP_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdlf_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            popped_next = front_byte;
                            cell_mode   = bdlf_pkg::CELL_SHIFT_DOWN;
                            count_next  = count_reg - bdlf_pkg::CNT_W'(1);
                        end
                    end
                    bdlf_pkg::OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = bdlf_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            pop_back_next = 1'b1;
                            count_next    = count_reg - bdlf_pkg::CNT_W'(1);
                        end
                    end
                    bdlf_pkg::OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        // Query and unused codes change nothing.
                    end
                endcase
            end

            bdlf_pkg::ST_SCAN:
            begin
                // Rotate one place; cell 0 shows logical index scan_reg.
                cell_mode = bdlf_pkg::CELL_SHIFT_DOWN;
                if (pop_back_reg && scan_reg == count_reg)
                begin
                    popped_next = front_byte;
                end
                if (!found_reg && scan_reg < count_reg && scan_byte == bdlf_pkg::NEWLINE_BYTE)
                begin
                    found_next = 1'b1;
                    pos_next   = bdlf_pkg::TOTAL_W'(scan_reg);
                end
                if (scan_last)
                begin
                    state_next = bdlf_pkg::ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + bdlf_pkg::CNT_W'(1);
                end
            end

            bdlf_pkg::ST_DONE:
            begin
                done       = 1'b1;
                state_next = bdlf_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = bdlf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers: cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bdlf_pkg::ST_IDLE;
            count_reg <= '0;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            scan_reg  <= scan_next;
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        data_reg      <= data_next;
        popped_reg    <= popped_next;
        status_reg    <= status_next;
        push_back_reg <= push_back_next;
        pop_back_reg  <= pop_back_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
    end

    assign popped_byte      = popped_reg;
    assign status           = status_reg;
    assign element_total    = bdlf_pkg::TOTAL_W'(count_reg);
    assign newline_position = pos_reg;

    // ---------------------------------------------------------------- assertions
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= bdlf_pkg::CNT_W'(bdlf_pkg::DEPTH))
        else $error("element count exceeds depth");

    a_full_total: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdlf_pkg::STATUS_FULL)
        |-> (element_total == bdlf_pkg::TOTAL_W'(bdlf_pkg::DEPTH)))
        else $error("dropped push reported with a queue that is not full");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bdlf_pkg::STATUS_EMPTY)
        |-> (element_total == '0 && popped_byte == 8'd0 && newline_position == '1))
        else $error("pop on empty queue reported with held bytes");

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == bdlf_pkg::ST_SCAN)
        else $error("result strobe without a finished scan");

endmodule
